// File: hw/rtl/bed_pkg.sv
`timescale 1ns / 1ps

package bed_pkg;

    localparam int POSITION_BITS = 16;
    localparam int COLUMN_BITS   = 16;
    localparam int CHAR_BITS     = 8;
    localparam int STATUS_BITS   = 3;
    localparam int NIBBLE_BITS   = 4;

    localparam logic [POSITION_BITS-1:0] POSITION_TOP = {POSITION_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0]   COLUMN_TOP   = {COLUMN_BITS{1'b1}};

    localparam logic [CHAR_BITS-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_BITS-1:0] CH_S         = 8'h73;
    localparam logic [CHAR_BITS-1:0] CH_T         = 8'h74;
    localparam logic [CHAR_BITS-1:0] CH_N         = 8'h6E;
    localparam logic [CHAR_BITS-1:0] CH_R         = 8'h72;
    localparam logic [CHAR_BITS-1:0] CH_X         = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_RETURN    = 8'h0D;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ESCAPE   = 3'd1,
        MODE_HEX_HIGH = 3'd2,
        MODE_HEX_LOW  = 3'd3,
        MODE_DISCARD  = 3'd4
    } t_mode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK                = 3'd0,
        ST_UNFINISHED_ESCAPE = 3'd1,
        ST_UNFINISHED_HEX    = 3'd2,
        ST_INVALID_HEX       = 3'd3,
        ST_INVALID_ESCAPE    = 3'd4
    } t_status;

    typedef struct packed {
        logic                   vld;
        logic [CHAR_BITS-1:0]   ch;
        t_status                status;
        logic [COLUMN_BITS-1:0] col;
        logic                   last;
    } t_result;

    // Clamp a byte position to the reported column width.
    function automatic logic [COLUMN_BITS-1:0] column_of(input logic [POSITION_BITS-1:0] pos);
        logic [31:0] w;
        w = 32'(pos);
        if (w > 32'(COLUMN_TOP)) begin
            return COLUMN_TOP;
        end
        return w[COLUMN_BITS-1:0];
    endfunction

    // Return {is_hex, value} for one ASCII byte.
    function automatic logic [NIBBLE_BITS:0] hex_nibble(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[NIBBLE_BITS-1:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[NIBBLE_BITS-1:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[NIBBLE_BITS-1:0]};
        end
        return {1'b0, d[NIBBLE_BITS-1:0]};
    endfunction

endpackage

// File: hw/rtl/backslash_escape_decoder_core.sv
`timescale 1ns / 1ps
// Channel | Handshake                     | Word fields
// input   | i_in_valid  / o_in_ready      | i_in_char[7:0], i_in_last
// output  | o_out_valid / i_out_ready     | o_out_char[7:0], o_status[2:0],
//         |                               | o_error_column[15:0], o_out_last
//
// One word per cycle while the result side does not stall. An accepted word is held
// in the input register, then decoded into the result register, which drives
// o_out_valid.
// While the result register holds a stalled word, input continues until a word
// that yields a result waits in the input register.
// Synchronous active-low reset clears valids and the decoder mode/position.
// Escape prefixes and discarded words produce no output word.

module backslash_escape_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bed_pkg::CHAR_BITS-1:0]     i_in_char,
    input  logic                              i_in_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bed_pkg::CHAR_BITS-1:0]     o_out_char,
    output logic [bed_pkg::STATUS_BITS-1:0]   o_status,
    output logic [bed_pkg::COLUMN_BITS-1:0]   o_error_column,
    output logic                              o_out_last
);

    // input register
    logic                          r_in_valid;
    logic [bed_pkg::CHAR_BITS-1:0] r_in_char;
    logic                          r_in_last;

    logic                          advance;
    logic                          can_load;
    bed_pkg::t_result              res;

    // Advance the held word when its result (if any) has a place to go.
    // Words that produce nothing advance regardless of the output side.
    assign advance    = r_in_valid && (!res.vld || can_load);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_in_char;
            r_in_last <= i_in_last;
        end
    end

    // Mode, hex nibble and position advance only with the word.
    bed_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .o_res     (res)
    );

    // Result register; holds its word while the sink stalls.
    bed_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && res.vld),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_char     (o_out_char),
        .o_status   (o_status),
        .o_col      (o_error_column),
        .o_last     (o_out_last)
    );

endmodule

// File: hw/rtl/bed_decode.sv
`timescale 1ns / 1ps

module bed_decode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic [bed_pkg::CHAR_BITS-1:0]    i_char,
    input  logic                             i_last,
    output bed_pkg::t_result                 o_res
);

    bed_pkg::t_mode                          r_mode, n_mode;
    logic [bed_pkg::NIBBLE_BITS-1:0]         r_nibble, n_nibble;
    logic [bed_pkg::POSITION_BITS-1:0]       r_pos, n_pos;
    logic [bed_pkg::COLUMN_BITS-1:0]         r_hex_col, n_hex_col;
    logic [bed_pkg::NIBBLE_BITS:0]           hex;
    bed_pkg::t_result                        res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= bed_pkg::MODE_NORMAL;
            r_nibble  <= '0;
            r_pos     <= '0;
            r_hex_col <= '0;
        end else if (i_advance) begin
            r_mode    <= n_mode;
            r_nibble  <= n_nibble;
            r_pos     <= n_pos;
            r_hex_col <= n_hex_col;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_nibble   = r_nibble;
        n_hex_col  = r_hex_col;
        hex        = bed_pkg::hex_nibble(i_char);
        res.vld    = 1'b0;
        res.ch     = '0;
        res.status = bed_pkg::ST_OK;
        res.col    = '0;
        res.last   = 1'b1;

        unique case (r_mode)
            bed_pkg::MODE_NORMAL: begin
                if (i_char != bed_pkg::CH_BACKSLASH) begin
                    res.vld  = 1'b1;
                    res.ch   = i_char;
                    res.last = i_last;
                end else if (i_last) begin
                    res.vld    = 1'b1;
                    res.status = bed_pkg::ST_UNFINISHED_ESCAPE;
                end else begin
                    n_mode = bed_pkg::MODE_ESCAPE;
                end
            end
            bed_pkg::MODE_ESCAPE: begin
                n_mode   = bed_pkg::MODE_NORMAL;
                res.vld  = 1'b1;
                res.last = i_last;
                unique case (i_char)
                    bed_pkg::CH_S:         res.ch = bed_pkg::CH_SPACE;
                    bed_pkg::CH_T:         res.ch = bed_pkg::CH_TAB;
                    bed_pkg::CH_N:         res.ch = bed_pkg::CH_NEWLINE;
                    bed_pkg::CH_R:         res.ch = bed_pkg::CH_RETURN;
                    bed_pkg::CH_BACKSLASH: res.ch = bed_pkg::CH_BACKSLASH;
                    bed_pkg::CH_X: begin
                        n_hex_col = bed_pkg::column_of(r_pos);
                        if (i_last) begin
                            res.status = bed_pkg::ST_UNFINISHED_HEX;
                            res.col    = bed_pkg::column_of(r_pos);
                        end else begin
                            res.vld = 1'b0;
                            n_mode  = bed_pkg::MODE_HEX_HIGH;
                        end
                    end
                    default: begin
                        res.status = bed_pkg::ST_INVALID_ESCAPE;
                        res.col    = bed_pkg::column_of(r_pos);
                        res.last   = 1'b1;
                        n_mode     = bed_pkg::MODE_DISCARD;
                    end
                endcase
            end
            bed_pkg::MODE_HEX_HIGH: begin
                if (i_last) begin
                    res.vld    = 1'b1;
                    res.status = bed_pkg::ST_UNFINISHED_HEX;
                    res.col    = r_hex_col;
                end else if (!hex[bed_pkg::NIBBLE_BITS]) begin
                    res.vld    = 1'b1;
                    res.status = bed_pkg::ST_INVALID_HEX;
                    res.col    = r_hex_col;
                    n_mode     = bed_pkg::MODE_DISCARD;
                end else begin
                    n_nibble = hex[bed_pkg::NIBBLE_BITS-1:0];
                    n_mode   = bed_pkg::MODE_HEX_LOW;
                end
            end
            bed_pkg::MODE_HEX_LOW: begin
                res.vld = 1'b1;
                n_mode  = bed_pkg::MODE_NORMAL;
                if (!hex[bed_pkg::NIBBLE_BITS]) begin
                    res.status = bed_pkg::ST_INVALID_HEX;
                    res.col    = r_hex_col;
                    n_mode     = bed_pkg::MODE_DISCARD;
                end else begin
                    res.ch   = {r_nibble, hex[bed_pkg::NIBBLE_BITS-1:0]};
                    res.last = i_last;
                end
            end
            bed_pkg::MODE_DISCARD: begin
                // drop everything up to the end of the string
            end
            default: begin
                n_mode = bed_pkg::MODE_NORMAL;
            end
        endcase

        if (i_last) begin
            n_mode = bed_pkg::MODE_NORMAL;
            n_pos  = '0;
        end else if (r_pos != bed_pkg::POSITION_TOP) begin
            n_pos = r_pos + bed_pkg::POSITION_BITS'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    assign o_res = res;

endmodule

// File: hw/rtl/bed_out_reg.sv
`timescale 1ns / 1ps

module bed_out_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  bed_pkg::t_result                  i_res,
    output logic                              o_can_load,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bed_pkg::CHAR_BITS-1:0]     o_char,
    output logic [bed_pkg::STATUS_BITS-1:0]   o_status,
    output logic [bed_pkg::COLUMN_BITS-1:0]   o_col,
    output logic                              o_last
);

    logic             r_valid;
    bed_pkg::t_result r_res;

    // free when empty or draining this cycle
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_char   = r_res.ch;
    assign o_status = r_res.status;
    assign o_col    = r_res.col;
    assign o_last   = r_res.last;

endmodule

// File: hw/rtl/bed_checker.sv
`timescale 1ns / 1ps

module bed_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [bed_pkg::CHAR_BITS-1:0]     o_out_char,
    input logic [bed_pkg::STATUS_BITS-1:0]   o_status,
    input logic [bed_pkg::COLUMN_BITS-1:0]   o_error_column,
    input logic                              o_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char)
            && $stable(o_status) && $stable(o_error_column) && $stable(o_out_last))
        else $error("output word changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != bed_pkg::ST_OK |-> o_out_last)
        else $error("error word without end-of-string flag");

    a_err_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != bed_pkg::ST_OK |-> o_out_char == '0)
        else $error("error word carries a character");

    a_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == bed_pkg::ST_OK
            || o_status == bed_pkg::ST_UNFINISHED_ESCAPE) |-> o_error_column == '0)
        else $error("column set on a word without a column");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= bed_pkg::ST_INVALID_ESCAPE)
        else $error("status code out of range");

endmodule

bind backslash_escape_decoder_core bed_checker u_bed_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_out_char     (o_out_char),
    .o_status       (o_status),
    .o_error_column (o_error_column),
    .o_out_last     (o_out_last)
);

// File: dv/backslash_escape_decoder_core_tb.sv
`timescale 1ns / 1ps

module backslash_escape_decoder_core_tb;
    import bed_pkg::*;

    // One decoded word as it leaves the block.
    typedef struct packed {
        logic [CHAR_BITS-1:0]   ch;
        t_status                status;
        logic [COLUMN_BITS-1:0] col;
        logic                   last;
    } decoded_word_t;

    // One row of the directed table. Typed rows carry their own answer;
    // the rest are left to the decoder model below.
    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
        bit                   typed;
        bit                   yields;
        decoded_word_t        want;
    } stim_row_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [CHAR_BITS-1:0]     i_in_char = '0;
    logic                     i_in_last = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [CHAR_BITS-1:0]     o_out_char;
    logic [STATUS_BITS-1:0]   o_status;
    logic [COLUMN_BITS-1:0]   o_error_column;
    logic                     o_out_last;

    // Decoder model state, reset values.
    t_mode                    dec_mode = MODE_NORMAL;
    logic [NIBBLE_BITS-1:0]   dec_nibble = '0;
    logic [POSITION_BITS-1:0] dec_pos = '0;
    logic [POSITION_BITS-1:0] dec_hex_col = '0;

    decoded_word_t            expected_words[$];
    stim_row_t                directed_rows[$];
    logic [CHAR_BITS-1:0]     pending_text[$];
    int                       mismatches = 0;
    int                       in_idle_pct = 0;
    int                       out_stall_pct = 0;

    backslash_escape_decoder_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_char      (i_in_char),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_status       (o_status),
        .o_error_column (o_error_column),
        .o_out_last     (o_out_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result side at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    function automatic decoded_word_t word_of(input logic [CHAR_BITS-1:0] c, input t_status st,
                                              input logic [COLUMN_BITS-1:0] col,
                                              input logic fin);
        decoded_word_t w;
        w.ch     = c;
        w.status = st;
        w.col    = col;
        w.last   = fin;
        return w;
    endfunction

    // Clamp a string position to the reported column width.
    function automatic logic [COLUMN_BITS-1:0] to_column(input logic [POSITION_BITS-1:0] p);
        if (64'(p) > 64'(COLUMN_TOP)) begin
            return COLUMN_TOP;
        end
        return COLUMN_BITS'(p);
    endfunction

    // Value of a hex digit in either case, -1 for anything else.
    function automatic int hex_val(input logic [CHAR_BITS-1:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    // Advance the decoder model by one input word and report the word it yields, if any.
    task automatic decode_byte(input logic [CHAR_BITS-1:0] c, input logic fin,
                               output bit has, output decoded_word_t w);
        logic [POSITION_BITS-1:0] here;
        int                       v;
        bit                       err;
        here = dec_pos;
        has  = 1'b0;
        err  = 1'b0;
        w    = '0;
        v    = hex_val(c);
        case (dec_mode)
            MODE_NORMAL: begin
                if (c != CH_BACKSLASH) begin
                    w   = word_of(c, ST_OK, '0, fin);
                    has = 1'b1;
                end else if (fin) begin
                    // a backslash cannot close a string
                    w   = word_of('0, ST_UNFINISHED_ESCAPE, '0, 1'b1);
                    has = 1'b1;
                end else begin
                    dec_mode = MODE_ESCAPE;
                end
            end
            MODE_ESCAPE: begin
                has      = 1'b1;
                dec_mode = MODE_NORMAL;
                case (c)
                    CH_S:         w = word_of(CH_SPACE, ST_OK, '0, fin);
                    CH_T:         w = word_of(CH_TAB, ST_OK, '0, fin);
                    CH_N:         w = word_of(CH_NEWLINE, ST_OK, '0, fin);
                    CH_R:         w = word_of(CH_RETURN, ST_OK, '0, fin);
                    CH_BACKSLASH: w = word_of(CH_BACKSLASH, ST_OK, '0, fin);
                    CH_X: begin
                        // remember where the hex escape starts for later errors
                        dec_hex_col = here;
                        if (fin) begin
                            w = word_of('0, ST_UNFINISHED_HEX, to_column(here), 1'b1);
                        end else begin
                            dec_mode = MODE_HEX_HIGH;
                            has      = 1'b0;
                        end
                    end
                    default: begin
                        w   = word_of('0, ST_INVALID_ESCAPE, to_column(here), 1'b1);
                        err = 1'b1;
                    end
                endcase
            end
            MODE_HEX_HIGH: begin
                if (fin) begin
                    // missing second digit wins over a bad first digit
                    w   = word_of('0, ST_UNFINISHED_HEX, to_column(dec_hex_col), 1'b1);
                    has = 1'b1;
                end else if (v < 0) begin
                    w   = word_of('0, ST_INVALID_HEX, to_column(dec_hex_col), 1'b1);
                    has = 1'b1;
                    err = 1'b1;
                end else begin
                    dec_nibble = NIBBLE_BITS'(v);
                    dec_mode   = MODE_HEX_LOW;
                end
            end
            MODE_HEX_LOW: begin
                has      = 1'b1;
                dec_mode = MODE_NORMAL;
                if (v < 0) begin
                    w   = word_of('0, ST_INVALID_HEX, to_column(dec_hex_col), 1'b1);
                    err = 1'b1;
                end else begin
                    w = word_of({dec_nibble, NIBBLE_BITS'(v)}, ST_OK, '0, fin);
                end
            end
            default: begin
                // discarding after an error: nothing comes out
            end
        endcase
        if (err) begin
            dec_mode = MODE_DISCARD;
        end
        // the last word of a string always rearms the decoder
        if (fin) begin
            dec_mode = MODE_NORMAL;
            dec_pos  = '0;
        end else if (dec_pos != POSITION_TOP) begin
            dec_pos = dec_pos + POSITION_BITS'(1);
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Check every word taken from the block against the oldest expectation.
    // Sample at the falling edge, where inputs and outputs are both settled.
    always @(negedge i_clk) begin
        decoded_word_t got;
        decoded_word_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = word_of(o_out_char, t_status'(o_status), o_error_column, o_out_last);
            if (expected_words.size() == 0) begin
                note_failure($sformatf("unexpected word: char %02h status %0d col %0d last %0b",
                                       got.ch, got.status, got.col, got.last));
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    note_failure({
                        $sformatf("word mismatch: expected char %02h status %0d col %0d last %0b",
                                  want.ch, want.status, want.col, want.last),
                        $sformatf(", got char %02h status %0d col %0d last %0b",
                                  got.ch, got.status, got.col, got.last)});
                end
            end
        end
    end

    // Offer one word, idling first at the current rate, and hold it until taken.
    task automatic send_word(input logic [CHAR_BITS-1:0] c, input logic fin);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        i_in_last  <= fin;
        do begin
            @(negedge i_clk);
        end while (!o_in_ready);
        @(posedge i_clk);
    endtask

    task automatic feed(input logic [CHAR_BITS-1:0] c, input logic fin);
        bit            has;
        decoded_word_t w;
        decode_byte(c, fin, has, w);
        if (has) begin
            expected_words.push_back(w);
        end
        send_word(c, fin);
    endtask

    task automatic row(input logic [CHAR_BITS-1:0] c, input logic fin, input bit typed,
                       input bit yields, input logic [CHAR_BITS-1:0] oc, input t_status st,
                       input logic [COLUMN_BITS-1:0] col, input logic olast);
        stim_row_t r;
        r.ch     = c;
        r.last   = fin;
        r.typed  = typed;
        r.yields = yields;
        r.want   = word_of(oc, st, col, olast);
        directed_rows.push_back(r);
    endtask

    // Row whose answer is left to the model.
    task automatic pred_row(input logic [CHAR_BITS-1:0] c, input logic fin);
        row(c, fin, 1'b0, 1'b0, '0, ST_OK, '0, 1'b0);
    endtask

    // Row that must produce no word.
    task automatic quiet_row(input logic [CHAR_BITS-1:0] c, input logic fin);
        row(c, fin, 1'b1, 1'b0, '0, ST_OK, '0, 1'b0);
    endtask

    function automatic logic [CHAR_BITS-1:0] hex_char(input int v);
        if (v < 10) begin
            return CHAR_BITS'(int'("0") + v);
        end
        if ($urandom_range(1)) begin
            return CHAR_BITS'(int'("A") + v - 10);
        end
        return CHAR_BITS'(int'("a") + v - 10);
    endfunction

    function automatic logic [CHAR_BITS-1:0] non_hex();
        logic [CHAR_BITS-1:0] c;
        do begin
            c = CHAR_BITS'($urandom_range(255));
        end while (hex_val(c) >= 0);
        return c;
    endfunction

    function automatic logic [CHAR_BITS-1:0] plain_char();
        logic [CHAR_BITS-1:0] c;
        do begin
            c = CHAR_BITS'($urandom_range(255));
        end while (c == CH_BACKSLASH);
        return c;
    endfunction

    // Build one random string: mostly plain bytes and well-formed escapes with random
    // content, some broken escapes, and now and then pure noise.
    task automatic make_string();
        int                   kind;
        logic [CHAR_BITS-1:0] c;
        pending_text.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                pending_text.push_back(CHAR_BITS'($urandom_range(255)));
            end
        end else begin
            repeat ($urandom_range(1, 8)) begin
                kind = $urandom_range(99);
                if (kind < 40) begin
                    pending_text.push_back(plain_char());
                end else if (kind < 60) begin
                    pending_text.push_back(CH_BACKSLASH);
                    case ($urandom_range(4))
                        0:       pending_text.push_back(CH_S);
                        1:       pending_text.push_back(CH_T);
                        2:       pending_text.push_back(CH_N);
                        3:       pending_text.push_back(CH_R);
                        default: pending_text.push_back(CH_BACKSLASH);
                    endcase
                end else if (kind < 80) begin
                    pending_text.push_back(CH_BACKSLASH);
                    pending_text.push_back(CH_X);
                    pending_text.push_back(hex_char($urandom_range(15)));
                    pending_text.push_back(hex_char($urandom_range(15)));
                end else if (kind < 88) begin
                    // unknown escape letter
                    do begin
                        c = CHAR_BITS'($urandom_range(255));
                    end while (c == CH_S || c == CH_T || c == CH_N || c == CH_R ||
                               c == CH_BACKSLASH || c == CH_X);
                    pending_text.push_back(CH_BACKSLASH);
                    pending_text.push_back(c);
                end else if (kind < 94) begin
                    // bad digit in either hex position
                    pending_text.push_back(CH_BACKSLASH);
                    pending_text.push_back(CH_X);
                    if ($urandom_range(1)) begin
                        pending_text.push_back(hex_char($urandom_range(15)));
                    end
                    pending_text.push_back(non_hex());
                end else begin
                    pending_text.push_back(CHAR_BITS'($urandom_range(255)));
                end
            end
            // leave an escape open at the end of some strings
            case ($urandom_range(19))
                0: begin
                    pending_text.push_back(CH_BACKSLASH);
                end
                1: begin
                    pending_text.push_back(CH_BACKSLASH);
                    pending_text.push_back(CH_X);
                end
                2: begin
                    pending_text.push_back(CH_BACKSLASH);
                    pending_text.push_back(CH_X);
                    pending_text.push_back(hex_char($urandom_range(15)));
                end
                3: begin
                    pending_text.push_back(CH_BACKSLASH);
                    pending_text.push_back(CH_X);
                    pending_text.push_back(non_hex());
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic send_text();
        foreach (pending_text[i]) begin
            feed(pending_text[i], i == pending_text.size() - 1);
        end
    endtask

    initial begin
        bit            has;
        decoded_word_t pred;
        stim_row_t     r;
        int            sent;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain words and the byte extremes
        row("A", 1'b0, 1'b1, 1'b1, "A", ST_OK, '0, 1'b0);
        row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, ST_OK, '0, 1'b0);
        row(8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, ST_OK, '0, 1'b1);
        // every named escape in one string
        quiet_row(CH_BACKSLASH, 1'b0);
        row(CH_S, 1'b0, 1'b1, 1'b1, CH_SPACE, ST_OK, '0, 1'b0);
        quiet_row(CH_BACKSLASH, 1'b0);
        row(CH_T, 1'b0, 1'b1, 1'b1, CH_TAB, ST_OK, '0, 1'b0);
        quiet_row(CH_BACKSLASH, 1'b0);
        row(CH_N, 1'b0, 1'b1, 1'b1, CH_NEWLINE, ST_OK, '0, 1'b0);
        quiet_row(CH_BACKSLASH, 1'b0);
        row(CH_R, 1'b0, 1'b1, 1'b1, CH_RETURN, ST_OK, '0, 1'b0);
        quiet_row(CH_BACKSLASH, 1'b0);
        row(CH_BACKSLASH, 1'b1, 1'b1, 1'b1, CH_BACKSLASH, ST_OK, '0, 1'b1);
        // hex escape closing the string
        pred_row(CH_BACKSLASH, 1'b0);
        pred_row(CH_X, 1'b0);
        pred_row("4", 1'b0);
        pred_row("f", 1'b1);
        // backslash as the last word
        row(CH_BACKSLASH, 1'b1, 1'b1, 1'b1, '0, ST_UNFINISHED_ESCAPE, '0, 1'b1);
        // hex escape letter as the last word
        quiet_row(CH_BACKSLASH, 1'b0);
        row(CH_X, 1'b1, 1'b1, 1'b1, '0, ST_UNFINISHED_HEX, 16'd1, 1'b1);
        // first hex digit as the last word, and not even a hex digit
        quiet_row(CH_BACKSLASH, 1'b0);
        quiet_row(CH_X, 1'b0);
        row("G", 1'b1, 1'b1, 1'b1, '0, ST_UNFINISHED_HEX, 16'd1, 1'b1);
        // bad second hex digit, then discard to the end of the string
        quiet_row(CH_BACKSLASH, 1'b0);
        quiet_row(CH_X, 1'b0);
        quiet_row("4", 1'b0);
        row("g", 1'b0, 1'b1, 1'b1, '0, ST_INVALID_HEX, 16'd1, 1'b1);
        quiet_row("z", 1'b1);
        // unknown escape letter mid-string, then discard
        row("a", 1'b0, 1'b1, 1'b1, "a", ST_OK, '0, 1'b0);
        quiet_row(CH_BACKSLASH, 1'b0);
        row("q", 1'b0, 1'b1, 1'b1, '0, ST_INVALID_ESCAPE, 16'd2, 1'b1);
        quiet_row("b", 1'b1);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            decode_byte(r.ch, r.last, has, pred);
            if (r.typed) begin
                if (r.yields) begin
                    expected_words.push_back(r.want);
                end
            end else if (has) begin
                expected_words.push_back(pred);
            end
            send_word(r.ch, r.last);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 72; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 72; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            sent = 0;
            while (sent < 475) begin
                make_string();
                send_text();
                sent += pending_text.size();
            end
        end
        i_in_valid <= 1'b0;

        // drain, then keep watching to catch stray words
        out_stall_pct = 0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
